/* hw/rtl/rcs_pkg.sv */
// Shared constants and types for the RGB contrast stretch block.
package rcs_pkg;

  localparam int PIXEL_BITS = 8;
  localparam int CNT_W      = (PIXEL_BITS > 1) ? $clog2(PIXEL_BITS) : 1;

  localparam logic [PIXEL_BITS-1:0] PIX_FULL = {PIXEL_BITS{1'b1}};
  localparam logic [PIXEL_BITS-1:0] PIX_ZERO = '0;
  localparam logic [CNT_W-1:0]      CNT_LAST = CNT_W'(PIXEL_BITS - 1);

  typedef logic [PIXEL_BITS-1:0] pix_t;

  typedef enum logic [1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_GATHER = 2'd1,
    MODE_APPLY  = 2'd2
  } mode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_HOLD
  } state_t;

  // Per-transaction commands from the sequencer to each lane.
  typedef struct packed {
    logic clear;
    logic gather;
    logic start;
  } lane_ctrl_t;

endpackage

/* hw/rtl/rcs_lane.sv */
// One color lane: channel extremes and an iterative restoring divider.
module rcs_lane (
  input  logic               clk,
  input  logic               rst_n,
  input  rcs_pkg::lane_ctrl_t ctrl,
  input  rcs_pkg::pix_t      pix,
  output logic               busy,
  output rcs_pkg::pix_t      res
);

  localparam int PB = rcs_pkg::PIXEL_BITS;

  rcs_pkg::pix_t            lo_r, lo_nxt;
  rcs_pkg::pix_t            hi_r, hi_nxt;
  rcs_pkg::pix_t            den_r, den_nxt;
  rcs_pkg::pix_t            rem_r, rem_nxt;
  rcs_pkg::pix_t            numlo_r, numlo_nxt;
  rcs_pkg::pix_t            quo_r, quo_nxt;
  rcs_pkg::pix_t            fixed_r, fixed_nxt;
  logic                     fix_en_r, fix_en_nxt;
  logic                     busy_r, busy_nxt;
  logic [rcs_pkg::CNT_W-1:0] cnt_r, cnt_nxt;

  rcs_pkg::pix_t            diff;
  logic [2*PB-1:0]          num;
  logic [PB:0]              trial;
  logic                     ge;

  always_comb begin
    // FULL * diff as (diff << PB) - diff
    diff  = pix - lo_r;
    num   = {diff, rcs_pkg::PIX_ZERO} - {rcs_pkg::PIX_ZERO, diff};
    trial = {rem_r, numlo_r[PB-1]};
    ge    = (trial >= {1'b0, den_r});

    lo_nxt     = lo_r;
    hi_nxt     = hi_r;
    den_nxt    = den_r;
    rem_nxt    = rem_r;
    numlo_nxt  = numlo_r;
    quo_nxt    = quo_r;
    fixed_nxt  = fixed_r;
    fix_en_nxt = fix_en_r;
    busy_nxt   = busy_r;
    cnt_nxt    = cnt_r;

    if (ctrl.clear) begin
      lo_nxt = rcs_pkg::PIX_FULL;
      hi_nxt = rcs_pkg::PIX_ZERO;
    end else if (ctrl.gather) begin
      if (pix < lo_r) lo_nxt = pix;
      if (pix > hi_r) hi_nxt = pix;
    end

    if (ctrl.start) begin
      den_nxt   = hi_r - lo_r;
      rem_nxt   = num[2*PB-1:PB];
      numlo_nxt = num[PB-1:0];
      quo_nxt   = rcs_pkg::PIX_ZERO;
      cnt_nxt   = '0;
      busy_nxt  = 1'b1;
      // flat channel passes through; out-of-range values saturate
      if (hi_r <= lo_r) begin
        fix_en_nxt = 1'b1;
        fixed_nxt  = pix;
      end else if (pix <= lo_r) begin
        fix_en_nxt = 1'b1;
        fixed_nxt  = rcs_pkg::PIX_ZERO;
      end else if (pix >= hi_r) begin
        fix_en_nxt = 1'b1;
        fixed_nxt  = rcs_pkg::PIX_FULL;
      end else begin
        fix_en_nxt = 1'b0;
        fixed_nxt  = rcs_pkg::PIX_ZERO;
      end
    end else if (busy_r) begin
      rem_nxt   = ge ? PB'(trial - {1'b0, den_r}) : trial[PB-1:0];
      numlo_nxt = {numlo_r[PB-2:0], 1'b0};
      quo_nxt   = {quo_r[PB-2:0], ge};
      cnt_nxt   = cnt_r + 1'b1;
      if (cnt_r == rcs_pkg::CNT_LAST) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lo_r   <= rcs_pkg::PIX_FULL;
      hi_r   <= rcs_pkg::PIX_ZERO;
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      lo_r   <= lo_nxt;
      hi_r   <= hi_nxt;
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    den_r    <= den_nxt;
    rem_r    <= rem_nxt;
    numlo_r  <= numlo_nxt;
    quo_r    <= quo_nxt;
    fixed_r  <= fixed_nxt;
    fix_en_r <= fix_en_nxt;
  end

  assign busy = busy_r;
  assign res  = fix_en_r ? fixed_r : quo_r;

endmodule

/* hw/rtl/rcs_merge.sv */
// Merge stage: gathers the three lane results into the output register.
module rcs_merge (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          load,
  input  rcs_pkg::pix_t red_res,
  input  rcs_pkg::pix_t green_res,
  input  rcs_pkg::pix_t blue_res,
  input  logic          out_ready,
  output logic          out_valid,
  output rcs_pkg::pix_t red_out,
  output rcs_pkg::pix_t green_out,
  output rcs_pkg::pix_t blue_out
);

  logic          valid_r, valid_nxt;
  rcs_pkg::pix_t red_r, green_r, blue_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      red_r   <= red_res;
      green_r <= green_res;
      blue_r  <= blue_res;
    end
  end

  assign out_valid = valid_r;
  assign red_out   = red_r;
  assign green_out = green_r;
  assign blue_out  = blue_r;

endmodule

/* hw/rtl/rgb_contrast_stretch_top.sv */
// Top level of the RGB contrast stretch block: sequencer, three lanes and merge.
//
// Input channel (in_valid/in_ready) carries a mode and one RGB pixel.
//   Clear resets the per-channel extremes, gather widens them; both finish in
//   the accepting cycle and give no output, so they run one per cycle in idle.
//   Apply stretches each channel as floor(FULL*(v-low)/(high-low)).
// Output channel (out_valid/out_ready) returns one transaction per apply.
// An apply is accepted in idle; the lanes then divide while the sequencer
// waits in run, and once they finish it loads the output register (or waits
// in hold for it) and goes back to idle. No new input is taken until then.
// Each lane uses a restoring divider, one quotient bit per cycle; the three
// lanes run in lockstep.
// A result waiting in the output register does not block new input; only a
// second finished apply result holds the block until the register drains.
// Reset (synchronous, active low) sets lows to full scale, highs to zero
// and empties the output register. Mode 3 is accepted and ignored.
module rgb_contrast_stretch_top (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [1:0]                         in_mode,
  input  logic [rcs_pkg::PIXEL_BITS-1:0]     in_red_in,
  input  logic [rcs_pkg::PIXEL_BITS-1:0]     in_green_in,
  input  logic [rcs_pkg::PIXEL_BITS-1:0]     in_blue_in,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [rcs_pkg::PIXEL_BITS-1:0]     out_red_out,
  output logic [rcs_pkg::PIXEL_BITS-1:0]     out_green_out,
  output logic [rcs_pkg::PIXEL_BITS-1:0]     out_blue_out
);

  rcs_pkg::state_t     state_r, state_nxt;
  rcs_pkg::lane_ctrl_t ctrl;
  logic                red_busy, green_busy, blue_busy;
  logic                lanes_busy;
  logic                load;
  rcs_pkg::pix_t       red_res, green_res, blue_res;

  assign lanes_busy = red_busy | green_busy | blue_busy;

  always_comb begin
    state_nxt   = state_r;
    in_ready    = 1'b0;
    load        = 1'b0;
    ctrl.clear  = 1'b0;
    ctrl.gather = 1'b0;
    ctrl.start  = 1'b0;
    case (state_r)
      rcs_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctrl.clear  = (in_mode == rcs_pkg::MODE_CLEAR);
          ctrl.gather = (in_mode == rcs_pkg::MODE_GATHER);
          ctrl.start  = (in_mode == rcs_pkg::MODE_APPLY);
          if (ctrl.start) state_nxt = rcs_pkg::ST_RUN;
        end
      end
      rcs_pkg::ST_RUN: begin
        if (!lanes_busy) begin
          if (!out_valid || out_ready) begin
            load      = 1'b1;
            state_nxt = rcs_pkg::ST_IDLE;
          end else begin
            state_nxt = rcs_pkg::ST_HOLD;
          end
        end
      end
      rcs_pkg::ST_HOLD: begin
        // hold the finished result until the output register frees up
        if (out_ready) begin
          load      = 1'b1;
          state_nxt = rcs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = rcs_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rcs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  rcs_lane u_lane_red (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .pix   (in_red_in),
    .busy  (red_busy),
    .res   (red_res)
  );

  rcs_lane u_lane_green (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .pix   (in_green_in),
    .busy  (green_busy),
    .res   (green_res)
  );

  rcs_lane u_lane_blue (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (ctrl),
    .pix   (in_blue_in),
    .busy  (blue_busy),
    .res   (blue_res)
  );

  rcs_merge u_merge (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (load),
    .red_res   (red_res),
    .green_res (green_res),
    .blue_res  (blue_res),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .red_out   (out_red_out),
    .green_out (out_green_out),
    .blue_out  (out_blue_out)
  );

endmodule

/* tb/sv/stretch_monitor.sv */
`timescale 1ns / 100ps
// Watches both channels of the contrast stretcher, predicts each stretched pixel and compares.
module stretch_monitor (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_ready,
  input  logic [1:0]    in_mode,
  input  rcs_pkg::pix_t in_red_in,
  input  rcs_pkg::pix_t in_green_in,
  input  rcs_pkg::pix_t in_blue_in,
  input  logic          out_valid,
  input  logic          out_ready,
  input  rcs_pkg::pix_t out_red_out,
  input  rcs_pkg::pix_t out_green_out,
  input  rcs_pkg::pix_t out_blue_out,
  output int            mismatch_count,
  output int            results_pending
);

  localparam int PRINT_LIMIT = 40;

  typedef logic [2*rcs_pkg::PIXEL_BITS-1:0] wide_t;

  typedef struct packed {
    rcs_pkg::pix_t red;
    rcs_pkg::pix_t green;
    rcs_pkg::pix_t blue;
  } rgb_t;

  rcs_pkg::pix_t chan_low  [3];
  rcs_pkg::pix_t chan_high [3];
  rgb_t stretched_q [$];
  int   lines_printed = 0;

  function automatic rcs_pkg::pix_t stretch_level(rcs_pkg::pix_t v, rcs_pkg::pix_t lo,
                                                  rcs_pkg::pix_t hi);
    rcs_pkg::pix_t offset;
    rcs_pkg::pix_t span;
    wide_t         scaled;
    if (hi <= lo) return v;
    if (v <= lo) return rcs_pkg::PIX_ZERO;
    if (v >= hi) return rcs_pkg::PIX_FULL;
    offset = v - lo;
    span   = hi - lo;
    scaled = wide_t'(rcs_pkg::PIX_FULL) * wide_t'(offset);
    return rcs_pkg::pix_t'(scaled / wide_t'(span));
  endfunction

  task automatic clear_extremes();
    for (int c = 0; c < 3; c++) begin
      chan_low[c]  = rcs_pkg::PIX_FULL;
      chan_high[c] = rcs_pkg::PIX_ZERO;
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (lines_printed < PRINT_LIMIT) begin
      $display("%0t: mismatch: %s", $time, msg);
      lines_printed++;
    end
    mismatch_count++;
  endtask

  always @(posedge clk) begin : watch
    rcs_pkg::pix_t px [3];
    rgb_t want;
    if (!rst_n) begin
      clear_extremes();
      stretched_q.delete();
      mismatch_count = 0;
    end else begin
      // Retire the output first so a result cannot match an apply taken at the same edge.
      if (out_valid && out_ready) begin
        if (stretched_q.size() == 0) begin
          report_mismatch($sformatf("result %0d/%0d/%0d with no apply outstanding",
                                    out_red_out, out_green_out, out_blue_out));
        end else begin
          want = stretched_q.pop_front();
          if (out_red_out !== want.red)
            report_mismatch($sformatf("red got %0d want %0d", out_red_out, want.red));
          if (out_green_out !== want.green)
            report_mismatch($sformatf("green got %0d want %0d", out_green_out, want.green));
          if (out_blue_out !== want.blue)
            report_mismatch($sformatf("blue got %0d want %0d", out_blue_out, want.blue));
        end
      end
      if (in_valid && in_ready) begin
        px = '{in_red_in, in_green_in, in_blue_in};
        case (in_mode)
          rcs_pkg::MODE_CLEAR: begin
            clear_extremes();
          end
          rcs_pkg::MODE_GATHER: begin
            for (int c = 0; c < 3; c++) begin
              if (px[c] < chan_low[c])  chan_low[c]  = px[c];
              if (px[c] > chan_high[c]) chan_high[c] = px[c];
            end
          end
          rcs_pkg::MODE_APPLY: begin
            want.red   = stretch_level(px[0], chan_low[0], chan_high[0]);
            want.green = stretch_level(px[1], chan_low[1], chan_high[1]);
            want.blue  = stretch_level(px[2], chan_low[2], chan_high[2]);
            stretched_q.push_back(want);
          end
          default: ;  // unused mode: drop
        endcase
      end
    end
    results_pending <= stretched_q.size();
  end

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// Testbench top: drives pixel transactions into the contrast stretcher and gives the verdict.
module tb;

  localparam logic [1:0] MODE_UNUSED   = 2'd3;
  localparam int         APPLY_LATENCY = rcs_pkg::PIXEL_BITS + 1;
  localparam int         STALL_LIMIT   = 2000;
  localparam int         ITEM_GOAL     = 1300;
  localparam int         PAUSE_FRAME   = 20;

  logic          clk;
  logic          rst_n;
  logic          in_valid;
  logic          in_ready;
  logic [1:0]    in_mode;
  rcs_pkg::pix_t in_red_in;
  rcs_pkg::pix_t in_green_in;
  rcs_pkg::pix_t in_blue_in;
  logic          out_valid;
  logic          out_ready;
  rcs_pkg::pix_t out_red_out;
  rcs_pkg::pix_t out_green_out;
  rcs_pkg::pix_t out_blue_out;

  int mismatch_count;
  int results_pending;
  int items_sent  = 0;
  int idle_cycles = 0;
  bit calm        = 1'b0;

  rgb_contrast_stretch_top DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_mode       (in_mode),
    .in_red_in     (in_red_in),
    .in_green_in   (in_green_in),
    .in_blue_in    (in_blue_in),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_red_out   (out_red_out),
    .out_green_out (out_green_out),
    .out_blue_out  (out_blue_out)
  );

  stretch_monitor u_monitor (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_red_in       (in_red_in),
    .in_green_in     (in_green_in),
    .in_blue_in      (in_blue_in),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red_out     (out_red_out),
    .out_green_out   (out_green_out),
    .out_blue_out    (out_blue_out),
    .mismatch_count  (mismatch_count),
    .results_pending (results_pending)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int draw_gap();
    if (calm) return 0;
    return ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
  endfunction

  function automatic rcs_pkg::pix_t near(int lo, int width);
    return rcs_pkg::pix_t'(lo + $urandom_range(0, width));
  endfunction

  // Returns at the rising edge where the transaction is taken.
  task automatic send_pixel(input logic [1:0] mode, input rcs_pkg::pix_t r,
                            input rcs_pkg::pix_t g, input rcs_pkg::pix_t b);
    int gap;
    gap = draw_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_mode     <= mode;
    in_red_in   <= r;
    in_green_in <= g;
    in_blue_in  <= b;
    @(negedge clk);
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    if (mode != MODE_UNUSED) items_sent++;
  endtask

  // Hold input until every outstanding apply has come back.
  task automatic wait_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (results_pending != 0) @(negedge clk);
    @(posedge clk);
  endtask

  initial begin : drain
    int gap;
    out_ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
      while (!out_valid) @(negedge clk);
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int            frame;
    int            n;
    int            base [3];
    int            span [3];
    rcs_pkg::pix_t px [3];
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_mode     <= rcs_pkg::MODE_CLEAR;
    in_red_in   <= rcs_pkg::PIX_ZERO;
    in_green_in <= rcs_pkg::PIX_ZERO;
    in_blue_in  <= rcs_pkg::PIX_ZERO;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Nothing gathered yet: every channel passes through.
    send_pixel(rcs_pkg::MODE_APPLY, 0, 128, 255);
    // A single gathered pixel gives a flat range.
    send_pixel(rcs_pkg::MODE_GATHER, 10, 20, 30);
    send_pixel(rcs_pkg::MODE_APPLY, 10, 20, 30);
    send_pixel(rcs_pkg::MODE_GATHER, 200, 180, 160);
    send_pixel(rcs_pkg::MODE_APPLY, 10, 20, 30);
    send_pixel(rcs_pkg::MODE_APPLY, 200, 180, 160);
    // Below and above the gathered range saturate.
    send_pixel(rcs_pkg::MODE_APPLY, 5, 250, 100);
    send_pixel(rcs_pkg::MODE_APPLY, 105, 100, 95);
    send_pixel(MODE_UNUSED, 0, 255, 0);
    send_pixel(rcs_pkg::MODE_APPLY, 11, 179, 159);
    send_pixel(rcs_pkg::MODE_CLEAR, 255, 0, 255);
    send_pixel(rcs_pkg::MODE_APPLY, 77, 0, 255);
    send_pixel(rcs_pkg::MODE_GATHER, 0, 0, 0);
    send_pixel(rcs_pkg::MODE_GATHER, 255, 255, 255);
    send_pixel(rcs_pkg::MODE_APPLY, 1, 254, 128);
    send_pixel(rcs_pkg::MODE_APPLY, 0, 255, 127);
    send_pixel(rcs_pkg::MODE_CLEAR, 0, 0, 0);
    // Green stays flat while red and blue span the full scale.
    send_pixel(rcs_pkg::MODE_GATHER, 0, 100, 255);
    send_pixel(rcs_pkg::MODE_GATHER, 255, 100, 0);
    send_pixel(rcs_pkg::MODE_APPLY, 128, 100, 200);
    send_pixel(rcs_pkg::MODE_APPLY, 254, 99, 1);
    send_pixel(MODE_UNUSED, 255, 255, 255);
    send_pixel(rcs_pkg::MODE_APPLY, 255, 101, 0);
    wait_results();

    frame = 0;
    while (items_sent < ITEM_GOAL) begin
      calm = ($urandom_range(0, 3) == 0);
      for (int c = 0; c < 3; c++) begin
        span[c] = ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(0, 255);
        base[c] = $urandom_range(0, 255 - span[c]);
      end
      if ($urandom_range(0, 9) != 0)
        send_pixel(rcs_pkg::MODE_CLEAR, rcs_pkg::pix_t'($urandom),
                   rcs_pkg::pix_t'($urandom), rcs_pkg::pix_t'($urandom));
      n = $urandom_range(1, 16);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 19) == 0) begin
          send_pixel(2'($urandom_range(rcs_pkg::MODE_CLEAR, MODE_UNUSED)),
                     rcs_pkg::pix_t'($urandom), rcs_pkg::pix_t'($urandom),
                     rcs_pkg::pix_t'($urandom));
        end else begin
          for (int c = 0; c < 3; c++) px[c] = near(base[c], span[c]);
          send_pixel(rcs_pkg::MODE_GATHER, px[0], px[1], px[2]);
        end
      end
      n = $urandom_range(1, 16);
      for (int i = 0; i < n; i++) begin
        for (int c = 0; c < 3; c++)
          px[c] = $urandom_range(0, 1) ? rcs_pkg::pix_t'($urandom) : near(base[c], span[c]);
        send_pixel(rcs_pkg::MODE_APPLY, px[0], px[1], px[2]);
      end
      frame++;
      if (frame == PAUSE_FRAME) wait_results();
    end

    calm = 1'b0;
    wait_results();
    repeat (2 * APPLY_LATENCY) @(posedge clk);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
